// ----- src/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// sle_pkg
// Types, character codes and helpers shared by the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int SLE_LINE_DEPTH = 64;

	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_DEL      = 8'h7F;
	localparam logic [7:0] CH_BELL     = 8'h07;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7E;

	localparam logic OP_EDIT = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] received_byte;
		logic [5:0] read_index;
	} sle_in_t;

	typedef struct packed {
		logic       out_kind;
		logic [7:0] data_byte;
		logic       line_ready;
		logic [5:0] line_length;
		logic       last;
	} sle_out_t;

	typedef enum logic [2:0] {
		JOB_READ,
		JOB_ECHO,
		JOB_FULL,
		JOB_CR,
		JOB_ERASE
	} sle_job_kind_t;

	// one decoded item on its way to the output serialiser
	typedef struct packed {
		sle_job_kind_t kind;
		logic [7:0]    data;
		logic          ready;
		logic [5:0]    len;
	} sle_job_t;

	function automatic logic [1:0] job_count(sle_job_kind_t kind);
		logic [1:0] n;
		unique case (kind)
			JOB_READ:  n = 2'd1;
			JOB_ECHO:  n = 2'd1;
			JOB_FULL:  n = 2'd2;
			JOB_CR:    n = 2'd2;
			JOB_ERASE: n = 2'd3;
			default:   n = 2'd1;
		endcase
		return n;
	endfunction

endpackage

// ----- src/sle_ram.sv -----
// ----------------------------------------------------------------------------
// sle_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/sle_edit.sv -----
// ----------------------------------------------------------------------------
// sle_edit
// Decodes each item, updates cursor, line store and valid bits, and holds the
// decoded item in the input stage register.
// ----------------------------------------------------------------------------
module sle_edit import sle_pkg::*; #(
	parameter int LINE_DEPTH = SLE_LINE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  sle_in_t  item,
	input  logic     item_valid,
	output logic     item_stall,
	output sle_job_t job,
	output logic     job_valid,
	input  logic     job_free
);

	localparam int CW = $clog2(LINE_DEPTH);
	localparam logic [CW-1:0] CUR_MAX = CW'(LINE_DEPTH - 1);

	logic [CW-1:0]         cursor_q;
	logic [LINE_DEPTH-1:0] vld_q;
	logic                  vld_s1;
	sle_job_t              job_s1;
	logic                  rd_ok_s1;

	logic          acc;
	logic          load;
	sle_job_t      job_d;
	logic [CW-1:0] cursor_d;
	logic          st_wr;
	logic          st_set;
	logic [CW-1:0] st_addr;
	logic          ram_we;
	logic          ram_re;
	logic [CW-1:0] rd_addr;
	logic          rd_ok;
	logic [7:0]    rdata;
	logic [8:0]    idx9;
	logic [8:0]    cur9;
	logic          is_print;

	assign item_stall = vld_s1 && !job_free;
	assign acc        = item_valid && !item_stall;

	assign idx9     = {3'b000, item.read_index};
	assign cur9     = 9'(cursor_q);
	assign rd_addr  = idx9[CW-1:0];
	assign rd_ok    = (idx9 < 9'(LINE_DEPTH)) && vld_q[rd_addr];
	assign is_print = (item.received_byte >= CH_PRINT_LO) &&
		(item.received_byte <= CH_PRINT_HI);

	always_comb begin
		load        = 1'b0;
		job_d.kind  = JOB_ECHO;
		job_d.data  = item.received_byte;
		job_d.ready = 1'b0;
		job_d.len   = '0;
		cursor_d    = cursor_q;
		st_wr       = 1'b0;
		st_set      = 1'b0;
		st_addr     = cursor_q;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		if (item.operation == OP_READ) begin
			load       = 1'b1;
			job_d.kind = JOB_READ;
			ram_re     = 1'b1;
		end else if (item.received_byte == CH_CR) begin
			load        = 1'b1;
			job_d.kind  = JOB_CR;
			job_d.ready = (cursor_q != '0);
			job_d.len   = cur9[5:0];
			st_wr       = 1'b1;
			cursor_d    = '0;
		end else if (item.received_byte == CH_BS || item.received_byte == CH_DEL) begin
			if (cursor_q != '0) begin
				load       = 1'b1;
				job_d.kind = JOB_ERASE;
				cursor_d   = cursor_q - CW'(1);
				st_wr      = 1'b1;
				st_addr    = cursor_q - CW'(1);
			end
		end else if (is_print) begin
			load = 1'b1;
			if (cursor_q != CUR_MAX) begin
				job_d.kind = JOB_ECHO;
				st_wr      = 1'b1;
				st_set     = 1'b1;
				ram_we     = 1'b1;
				cursor_d   = cursor_q + CW'(1);
			end else begin
				job_d.kind = JOB_FULL;
			end
		end
	end

	sle_ram #(
		.WIDTH(8),
		.DEPTH(LINE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (acc && ram_we),
		.waddr(cursor_q),
		.wdata(item.received_byte),
		.re   (acc && ram_re),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			vld_q    <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (acc) begin
				cursor_q <= cursor_d;
				if (st_wr) begin
					vld_q[st_addr] <= st_set;
				end
			end
			if (!item_stall) begin
				vld_s1 <= acc && load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && load) begin
			job_s1   <= job_d;
			rd_ok_s1 <= rd_ok;
		end
	end

	always_comb begin
		job = job_s1;
		if (job_s1.kind == JOB_READ) begin
			job.data = rd_ok_s1 ? rdata : 8'h00;
		end
	end

	assign job_valid = vld_s1;

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CUR_MAX)
		else $error("cursor beyond last column");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> vld_s1 && !job_free)
		else $error("stall without a held item");

	a_cr_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		acc && item.operation == OP_EDIT && item.received_byte == CH_CR |=> cursor_q == '0)
		else $error("cursor not rewound after CR");
`endif

endmodule

// ----- src/sle_emit.sv -----
// ----------------------------------------------------------------------------
// sle_emit
// Output stage: holds one decoded item and sends its one to three results.
// ----------------------------------------------------------------------------
module sle_emit import sle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  sle_job_t job,
	input  logic     job_valid,
	output logic     job_free,
	output sle_out_t result,
	output logic     result_valid,
	input  logic     result_stall
);

	logic       vld_s2;
	logic [1:0] idx_s2;
	sle_job_t   job_s2;
	logic       take;
	logic       done;

	assign result_valid = vld_s2;
	assign take         = vld_s2 && !result_stall;
	assign done         = take && result.last;
	assign job_free     = !vld_s2 || done;

	always_comb begin
		result = '0;
		result.out_kind = KIND_ECHO;
		unique case (job_s2.kind)
			JOB_READ: begin
				result.out_kind  = KIND_READ;
				result.data_byte = job_s2.data;
				result.last      = 1'b1;
			end
			JOB_ECHO: begin
				result.data_byte = job_s2.data;
				result.last      = 1'b1;
			end
			JOB_FULL: begin
				result.data_byte = (idx_s2 == 2'd0) ? job_s2.data : CH_BELL;
				result.last      = (idx_s2 != 2'd0);
			end
			JOB_CR: begin
				if (idx_s2 == 2'd0) begin
					result.data_byte = CH_CR;
				end else begin
					result.data_byte   = CH_LF;
					result.line_ready  = job_s2.ready;
					result.line_length = job_s2.ready ? job_s2.len : 6'd0;
					result.last        = 1'b1;
				end
			end
			JOB_ERASE: begin
				result.data_byte = (idx_s2 == 2'd1) ? CH_SPACE : CH_BS;
				result.last      = (idx_s2 == 2'd2);
			end
			default: begin
				result.last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			idx_s2 <= '0;
		end else if (job_free) begin
			vld_s2 <= job_valid;
			idx_s2 <= '0;
		end else if (take) begin
			idx_s2 <= idx_s2 + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_free && job_valid) begin
			job_s2 <= job;
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> idx_s2 < job_count(job_s2.kind))
		else $error("result index past item's result count");

	a_keep_going: assert property (@(posedge clk) disable iff (!arst_n)
		take && !result.last |=> result_valid && idx_s2 == $past(idx_s2) + 2'd1)
		else $error("item dropped before its last result");

	a_ready_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.line_ready |-> result.last && result.data_byte == CH_LF)
		else $error("line ready off the LF echo");
`endif

endmodule

// ----- src/serial_line_editor_echo_core.sv -----
// ----------------------------------------------------------------------------
// serial_line_editor_echo_core
// Terminal line editor with echo for received serial bytes.
// ----------------------------------------------------------------------------
// An item is decoded as it is taken, the cursor and line store are updated at
// once, and the item is held in the input stage register and then moves to the
// output stage, which hands out its results one per cycle while result_stall is
// low (one for a stored byte or a read, two for CR or a full line, three for an
// erase, none for ignored bytes). A new item is stalled while the input stage
// holds an item that the output stage cannot yet take; a read takes its data
// from the registered read port of the store RAM. The store is cleared at reset
// through per-entry valid bits, so no clearing pass is needed.
module serial_line_editor_echo_core import sle_pkg::*; #(
	parameter int LINE_DEPTH = SLE_LINE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  sle_in_t  item,
	input  logic     item_valid,
	output logic     item_stall,
	output sle_out_t result,
	output logic     result_valid,
	input  logic     result_stall
);

	sle_job_t job;
	logic     job_valid;
	logic     job_free;

	sle_edit #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_edit (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.job       (job),
		.job_valid (job_valid),
		.job_free  (job_free)
	);

	sle_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (job),
		.job_valid   (job_valid),
		.job_free    (job_free),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule
